// ----- hw/rtl/ihq_pkg.sv -----
// Package for the indexed max-heap queue: operation and status codes, field widths.
// Used by indexed_max_heap_queue_core. No dependencies.
package ihq_pkg;
	localparam int IdW  = 10;
	localparam int PosW = 11;
	localparam int IdCount = 1024;

	typedef enum logic [1:0] {
		FN_INSERT  = 2'd0,
		FN_EXTRACT = 2'd1,
		FN_DELETE  = 2'd2,
		FN_QUERY   = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2,
		ST_RANGE = 2'd3
	} status_t;
endpackage

// ----- hw/rtl/indexed_max_heap_queue_core.sv -----
// Indexed binary max-heap of ids with an id-to-position table, in two synchronous memories.
// Depends on ihq_pkg.
//
//  channel | valid     | stall     | payload
//  in      | in_valid  | in_stall  | func, item_id, position
//  out     | out_valid | out_stall | result_id, result_position, entry_count, status
//
// One transaction at a time. Error results pass through S_DONE only; queries first read the
// position table in S_QRD and S_QWAIT. Insert walks up, each level a read, a compare and two
// writes; extract and delete walk down, each level two child reads, a compare and two writes,
// then walk up as insert does, all bound by the heap memory port.
// After reset the position table is swept clear, every entry, with in_stall high.
// The result waits in an output register; the next transaction is taken once it has gone.
module indexed_max_heap_queue_core
	import ihq_pkg::*;
#(
	parameter int CAPACITY = 1024
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  logic [1:0]      func,
	input  logic [IdW-1:0]  item_id,
	input  logic [PosW-1:0] position,
	output logic            out_valid,
	input  logic            out_stall,
	output logic [IdW-1:0]  result_id,
	output logic [PosW-1:0] result_position,
	output logic [PosW-1:0] entry_count,
	output logic [1:0]      status
);
	localparam int AW = $clog2(CAPACITY + 1);
	localparam int CW = AW + 1;

	typedef enum logic [4:0] {
		S_CLEAR, S_IDLE, S_QRD, S_QWAIT,
		S_INS, S_UPRD, S_UPW, S_UPCMP,
		S_RMRD, S_RMW, S_RMLAST, S_RMPUT,
		S_DNRD, S_DNW1, S_DNW2, S_DNCMP, S_DONE
	} state_t;

	state_t          state_q;
	logic [AW-1:0]   size_q;
	logic [AW-1:0]   p_q, c_q;
	logic [IdW-1:0]  a_q, b_q, l_q, rid_q;
	logic [1:0]      fn_q;
	logic [IdW-1:0]  qid_q;
	logic [9:0]      clr_q;
	logic [1:0]      sub_q;

	logic [IdW-1:0]  heap_mem [0:CAPACITY];
	logic [PosW-1:0] ptab_mem [0:IdCount-1];

	logic            h_we, t_we;
	logic [AW-1:0]   h_wa, h_ra;
	logic [IdW-1:0]  h_wd, h_rd;
	logic [IdW-1:0]  t_wa, t_ra;
	logic [PosW-1:0] t_wd, t_rd;

	logic            ov_q;
	logic [IdW-1:0]  orid_q;
	logic [PosW-1:0] opos_q, ocnt_q;
	logic [1:0]      ost_q;

	always_ff @(posedge clk) begin
		if (h_we) heap_mem[h_wa] <= h_wd;
		h_rd <= heap_mem[h_ra];
		if (t_we) ptab_mem[t_wa] <= t_wd;
		t_rd <= ptab_mem[t_ra];
	end

	// single write per memory per cycle; writes sequenced by sub_q in S_UPW, by S_DNW1/S_DNW2 going down
	logic [AW-1:0] n1;
	assign n1 = size_q + AW'(1);

	always_comb begin
		h_we = 1'b0; h_wa = p_q; h_wd = a_q; h_ra = p_q;
		t_we = 1'b0; t_wa = a_q; t_wd = PosW'(p_q); t_ra = qid_q;
		case (state_q)
			S_CLEAR: begin
				t_we = 1'b1; t_wa = clr_q; t_wd = '0;
			end
			S_INS: begin
				h_we = 1'b1; h_wa = n1; h_wd = qid_q;
				t_we = 1'b1; t_wa = qid_q; t_wd = PosW'(n1);
			end
			S_UPRD: h_ra = p_q >> 1;
			S_UPW: begin
				if (sub_q == 2'd0) begin
					h_we = 1'b1; h_wa = p_q; h_wd = b_q;
					t_we = 1'b1; t_wa = b_q; t_wd = PosW'(p_q);
				end else begin
					h_we = 1'b1; h_wa = p_q >> 1; h_wd = a_q;
					t_we = 1'b1; t_wa = a_q; t_wd = PosW'(p_q >> 1);
				end
			end
			S_RMRD: h_ra = p_q;
			S_RMW: begin
				t_we = 1'b1; t_wa = rid_q; t_wd = '0;
				h_ra = size_q;
			end
			S_RMPUT: begin
				h_we = 1'b1; h_wa = p_q; h_wd = l_q;
				t_we = 1'b1; t_wa = l_q; t_wd = PosW'(p_q);
			end
			S_DNRD: h_ra = (sub_q == 2'd0) ? c_q : c_q + AW'(1);
			S_DNW1: begin
				h_we = 1'b1; h_wa = p_q; h_wd = b_q;
				t_we = 1'b1; t_wa = b_q; t_wd = PosW'(p_q);
			end
			S_DNW2: begin
				h_we = 1'b1; h_wa = c_q; h_wd = a_q;
				t_we = 1'b1; t_wa = a_q; t_wd = PosW'(c_q);
			end
			default: ;
		endcase
	end

	logic [CW-1:0] c2;
	assign c2 = {p_q, 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			size_q  <= '0;
			ov_q    <= 1'b0;
			sub_q   <= '0;
		end else begin
			if (ov_q && !out_stall) ov_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 10'd1;
					if (clr_q == 10'(IdCount - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_valid && !ov_q) begin
						fn_q  <= func;
						qid_q <= item_id;
						rid_q <= '0;
						orid_q <= '0; opos_q <= '0; ost_q <= ST_OK;
						case (func_t'(func))
							FN_INSERT: begin
								if (CW'(size_q) >= CW'(CAPACITY)) begin
									ost_q <= ST_FULL; state_q <= S_DONE;
								end else state_q <= S_INS;
							end
							FN_EXTRACT: begin
								if (size_q == '0) begin
									ost_q <= ST_EMPTY; state_q <= S_DONE;
								end else begin
									p_q <= AW'(1); state_q <= S_RMRD;
								end
							end
							FN_DELETE: begin
								if (size_q == '0) begin
									ost_q <= ST_EMPTY; state_q <= S_DONE;
								end else if (position == '0 ||
									{{(CW > PosW ? CW-PosW : 1){1'b0}}, position} >
									{{(PosW >= CW ? PosW-CW+1 : 1){1'b0}}, size_q}) begin
									ost_q <= ST_RANGE; state_q <= S_DONE;
								end else begin
									p_q <= AW'(position); state_q <= S_RMRD;
								end
							end
							default: state_q <= S_QRD;
						endcase
					end
				end
				S_QRD: state_q <= S_QWAIT;
				S_QWAIT: begin
					opos_q <= t_rd; state_q <= S_DONE;
				end
				S_INS: begin
					size_q <= n1; p_q <= n1; a_q <= qid_q;
					state_q <= S_UPCMP;
				end
				S_UPCMP: begin
					if (p_q > AW'(1)) state_q <= S_UPRD;
					else begin
						if (fn_q == FN_INSERT) state_q <= S_QRD;
						else state_q <= S_DONE;
					end
					sub_q <= '0;
				end
				S_UPRD: begin
					if (sub_q == 2'd0) sub_q <= 2'd1;
					else begin
						sub_q <= '0;
						if (a_q > h_rd) begin
							b_q <= h_rd; state_q <= S_UPW;
						end else state_q <= (fn_q == FN_INSERT) ? S_QRD : S_DONE;
					end
				end
				S_UPW: begin
					if (sub_q == 2'd0) sub_q <= 2'd1;
					else begin
						sub_q <= '0; p_q <= p_q >> 1; state_q <= S_UPCMP;
					end
				end
				S_RMRD: begin
					if (sub_q == 2'd0) sub_q <= 2'd1;
					else begin
						sub_q <= '0; rid_q <= h_rd; state_q <= S_RMW;
					end
				end
				S_RMW: begin
					state_q <= S_RMLAST;
					size_q <= size_q - AW'(1);
				end
				S_RMLAST: begin
					l_q <= h_rd;
					orid_q <= rid_q;
					if (size_q >= p_q) state_q <= S_RMPUT;
					else state_q <= S_DONE;
				end
				S_RMPUT: begin
					a_q <= l_q; c_q <= c2[AW-1:0]; sub_q <= '0;
					state_q <= (c2 <= CW'(size_q)) ? S_DNRD : S_UPCMP;
				end
				S_DNRD: begin
					sub_q <= sub_q + 2'd1;
					if (sub_q == 2'd1) b_q <= h_rd;
					if (sub_q == 2'd1 && c_q == size_q) sub_q <= 2'd3;
					if (sub_q == 2'd2) begin
						if (!(b_q > h_rd)) begin
							b_q <= h_rd; c_q <= c_q + AW'(1);
						end
					end
					if (sub_q == 2'd3) begin
						sub_q <= '0;
						if (a_q > b_q) state_q <= S_UPCMP;
						else state_q <= S_DNW1;
					end
				end
				S_DNW1: state_q <= S_DNW2;
				S_DNW2: begin
					p_q <= c_q; state_q <= S_DNCMP;
				end
				S_DNCMP: begin
					c_q <= c2[AW-1:0];
					state_q <= (c2 <= CW'(size_q)) ? S_DNRD : S_UPCMP;
				end
				S_DONE: begin
					ov_q <= 1'b1;
					ocnt_q <= PosW'(size_q);
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_stall        = (state_q != S_IDLE) || ov_q;
	assign out_valid       = ov_q;
	assign result_id       = orid_q;
	assign result_position = opos_q;
	assign entry_count     = ocnt_q;
	assign status          = ost_q;

	a_size_cap: assert property (@(posedge clk) disable iff (!arst_n)
		CW'(size_q) <= CW'(CAPACITY))
		else $error("heap size above capacity");
	a_busy_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> in_stall)
		else $error("input taken while busy");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(result_id) && $stable(status)))
		else $error("stalled result changed");
	a_err_size: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !$past(out_valid) && status != ST_OK) |-> entry_count == PosW'(size_q))
		else $error("error changed size");
endmodule

// ----- sim/indexed_max_heap_queue_checker.sv -----
// Checker for the indexed max-heap queue: watches both channels, keeps its own heap and
// id-to-position table, and compares each result transaction. Depends on ihq_pkg.
`timescale 1ns / 1ps
module indexed_max_heap_queue_checker
	import ihq_pkg::*;
#(
	parameter int CAPACITY = 1024
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            in_stall,
	input  logic [1:0]      func,
	input  logic [IdW-1:0]  item_id,
	input  logic [PosW-1:0] position,
	input  logic            out_valid,
	input  logic            out_stall,
	input  logic [IdW-1:0]  result_id,
	input  logic [PosW-1:0] result_position,
	input  logic [PosW-1:0] entry_count,
	input  logic [1:0]      status,
	output int              fail_count,
	output int              pending,
	output int              heap_size
);
	typedef struct packed {
		logic [IdW-1:0]  rid;
		logic [PosW-1:0] rpos;
		logic [PosW-1:0] cnt;
		status_t         st;
	} heap_result_t;

	int unsigned  heap_ids [CAPACITY+1];
	int unsigned  id_pos [IdCount];
	int unsigned  n_entries;
	heap_result_t result_queue [$];

	assign pending = result_queue.size();
	assign heap_size = n_entries;

	function automatic void put_entry(int unsigned p, int unsigned id);
		heap_ids[p] = id;
		id_pos[id] = p;
	endfunction

	function automatic void heap_down(int unsigned p);
		int unsigned c, a, b;
		c = 2 * p;
		while (c <= n_entries) begin
			if (c + 1 <= n_entries && !(heap_ids[c] > heap_ids[c+1]))
				c++;
			if (heap_ids[p] > heap_ids[c])
				return;
			a = heap_ids[p];
			b = heap_ids[c];
			put_entry(p, b);
			put_entry(c, a);
			p = c;
			c = 2 * p;
		end
	endfunction

	function automatic void heap_up(int unsigned p);
		int unsigned q, a, b;
		while (p > 1) begin
			q = p / 2;
			a = heap_ids[p];
			b = heap_ids[q];
			if (!(a > b))
				return;
			put_entry(p, b);
			put_entry(q, a);
			p = q;
		end
	endfunction

	function automatic int unsigned take_at(int unsigned p);
		int unsigned id;
		id = heap_ids[p];
		id_pos[id] = 0;
		n_entries--;
		if (n_entries >= p) begin
			put_entry(p, heap_ids[n_entries+1]);
			heap_down(p);
			heap_up(p);
		end
		return id;
	endfunction

	function automatic heap_result_t apply_op(func_t f, int unsigned id, int unsigned pos);
		heap_result_t r;
		r = '0;
		r.st = ST_OK;
		case (f)
			FN_INSERT: begin
				if (n_entries >= CAPACITY)
					r.st = ST_FULL;
				else begin
					n_entries++;
					put_entry(n_entries, id);
					heap_up(n_entries);
					r.rpos = PosW'(id_pos[id]);
				end
			end
			FN_EXTRACT: begin
				if (n_entries == 0)
					r.st = ST_EMPTY;
				else
					r.rid = IdW'(take_at(1));
			end
			FN_DELETE: begin
				if (n_entries == 0)
					r.st = ST_EMPTY;
				else if (pos == 0 || pos > n_entries)
					r.st = ST_RANGE;
				else
					r.rid = IdW'(take_at(pos));
			end
			default: r.rpos = PosW'(id_pos[id]);
		endcase
		r.cnt = PosW'(n_entries);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		heap_result_t e;
		if (!arst_n) begin
			foreach (id_pos[i])
				id_pos[i] = 0;
			n_entries = 0;
			result_queue.delete();
			fail_count = 0;
		end else begin
			if (in_valid && !in_stall)
				result_queue.push_back(apply_op(func_t'(func), item_id, position));
			if (out_valid && !out_stall) begin
				if (result_queue.size() == 0) begin
					$error("unexpected result transaction");
					fail_count++;
				end else begin
					e = result_queue.pop_front();
					if (result_id !== e.rid) begin
						$error("result_id: expected %0d, got %0d", e.rid, result_id);
						fail_count++;
					end
					if (result_position !== e.rpos) begin
						$error("result_position: expected %0d, got %0d", e.rpos,
							result_position);
						fail_count++;
					end
					if (entry_count !== e.cnt) begin
						$error("entry_count: expected %0d, got %0d", e.cnt, entry_count);
						fail_count++;
					end
					if (status !== e.st) begin
						$error("status: expected %0d, got %0d", e.st, status);
						fail_count++;
					end
				end
			end
		end
	end
endmodule

// ----- sim/indexed_max_heap_queue_core_tb.sv -----
// Testbench top for indexed_max_heap_queue_core: directed and random heap operations with
// random idling on both channels. Depends on ihq_pkg and indexed_max_heap_queue_checker.
`timescale 1ns / 1ps
module indexed_max_heap_queue_core_tb;
	import ihq_pkg::*;

	localparam int CAP = 1024;
	localparam longint CycleLimit = 2000000;

	logic            clk = 1'b0;
	logic            arst_n = 1'b0;
	logic            in_valid = 1'b0;
	logic            in_stall;
	logic [1:0]      func = FN_QUERY;
	logic [IdW-1:0]  item_id = '0;
	logic [PosW-1:0] position = '0;
	logic            out_valid;
	logic            out_stall = 1'b1;
	logic [IdW-1:0]  result_id;
	logic [PosW-1:0] result_position;
	logic [PosW-1:0] entry_count;
	logic [1:0]      status;
	int              fail_count, pending, heap_size;
	int              op_tally [4];
	longint          cycles = 0;
	bit              draining = 1'b0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	indexed_max_heap_queue_core #(.CAPACITY(CAP)) u_top (.*);

	indexed_max_heap_queue_checker #(.CAPACITY(CAP)) u_checker (.*);

	// valid stays high between back-to-back transactions
	task automatic send_op(func_t f, int unsigned id, int unsigned pos);
		int unsigned gap;
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		item_id <= id;
		position <= pos;
		op_tally[f]++;
		do
			@(posedge clk);
		while (in_stall);
	endtask

	// receiver: random stall per transaction, with runs of no stall
	always @(posedge clk) begin
		int unsigned hold;
		if (arst_n) begin
			if (draining || $urandom_range(0, 3) == 0)
				hold = 0;
			else
				hold = $urandom_range(0, 13);
			if (hold != 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			do
				@(posedge clk);
			while (!(out_valid));
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		int unsigned r, n;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		// directed: empty errors, extremes, duplicates, range errors
		send_op(FN_EXTRACT, 0, 0);
		send_op(FN_DELETE, 0, 1);
		send_op(FN_QUERY, 1023, 0);
		send_op(FN_INSERT, 0, 0);
		send_op(FN_INSERT, 1023, 0);
		send_op(FN_INSERT, 512, 0);
		send_op(FN_INSERT, 512, 0);
		send_op(FN_INSERT, 341, 0);
		send_op(FN_QUERY, 512, 0);
		send_op(FN_QUERY, 1023, 0);
		send_op(FN_DELETE, 0, 2047);
		send_op(FN_DELETE, 0, 0);
		send_op(FN_DELETE, 0, 6);
		send_op(FN_DELETE, 0, 2);
		send_op(FN_DELETE, 0, 4);
		send_op(FN_EXTRACT, 0, 0);
		send_op(FN_EXTRACT, 0, 0);
		send_op(FN_EXTRACT, 0, 0);
		send_op(FN_EXTRACT, 0, 0);
		// fill to capacity, then hit full
		for (int i = 0; i < CAP; i++)
			send_op(FN_INSERT, $urandom_range(0, 1023), 0);
		send_op(FN_INSERT, 682, 0);
		send_op(FN_DELETE, 0, CAP);
		send_op(FN_DELETE, 0, 1);
		send_op(FN_INSERT, 1023, 0);
		send_op(FN_INSERT, 1, 0);
		// random mix on a nearly full heap
		for (int i = 0; i < 750; i++) begin
			r = $urandom_range(0, 99);
			n = heap_size;
			if (r < 40)
				send_op(FN_INSERT, $urandom_range(0, 1023), 0);
			else if (r < 55)
				send_op(FN_EXTRACT, 0, 0);
			else if (r < 75)
				send_op(FN_DELETE, 0, (n > 0 && r < 72) ? $urandom_range(1, n) :
					$urandom_range(0, 2047));
			else
				send_op(FN_QUERY, $urandom_range(0, 1023), $urandom_range(0, 2047));
		end
		in_valid <= 1'b0;
		draining = 1'b1;
		while (pending != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		$display("run: %0d inserts, %0d extracts, %0d deletes, %0d queries",
			op_tally[FN_INSERT], op_tally[FN_EXTRACT], op_tally[FN_DELETE],
			op_tally[FN_QUERY]);
		$display("run: heap filled to capacity once; %0d mismatches", fail_count);
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule
